>>> rtl/efm_pkg.sv
// Shared constants, register codes and beat types for the ethertype frame filter.
package efm_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 2048;
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned LEN_W = 11;
  localparam int unsigned MAC_W = 48;
  localparam int unsigned TYPE_W = 16;
  localparam int unsigned EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam int unsigned HDR_LEN = 14;
  localparam int unsigned DST_END = 6;
  localparam int unsigned SRC_END = 12;
  localparam int unsigned TYPE_HI_IDX = 12;
  localparam int unsigned TYPE_LO_IDX = 13;

  localparam logic [TYPE_W-1:0] TYPE_RESET = 16'h88B6;
  localparam logic [LEN_W-1:0] CAP_RESET = 11'd1500;
  localparam logic [7:0] BCAST_BYTE = 8'hFF;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = MAC_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_OWN_MAC = 2'd0,
    REG_MATCH_TYPE = 2'd1,
    REG_PAYLOAD_CAP = 2'd2
  } efm_reg_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } efm_beat_t;

  typedef struct packed {
    logic             payload_valid;
    logic [7:0]       payload_byte;
    logic             frame_done;
    logic             accepted;
    logic [MAC_W-1:0] source_address;
    logic [LEN_W-1:0] pay_len;
  } efm_result_t;

endpackage

>>> rtl/efm_in_stage.sv
// Input register stage: captures one received byte beat.
module efm_in_stage
  import efm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  efm_beat_t in_beat_i,
  output logic      beat_valid_o,
  output efm_beat_t beat_o,
  input  logic      advance_i
);

  logic      valid_q, valid_d;
  efm_beat_t beat_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      beat_q <= in_beat_i;
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o = beat_q;

endmodule

>>> rtl/efm_frame_check.sv
// Configuration registers, per-frame header state and verdict logic.
module efm_frame_check
  import efm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  advance_i,
  input  efm_beat_t             beat_i,
  output efm_result_t           result_o
);

  logic [MAC_W-1:0]  own_mac_q;
  logic [TYPE_W-1:0] match_type_q;
  logic [LEN_W-1:0]  capacity_q;

  logic [CNT_W-1:0]  count_q, count_d;
  logic              dst_own_q, dst_own_d;
  logic              dst_bc_q, dst_bc_d;
  logic [7:0]        type_hi_q, type_hi_d;
  logic              type_ok_q, type_ok_d;
  logic [MAC_W-1:0]  src_q, src_d;

  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  cnt_upd;
  logic              keep;
  logic [7:0]        want;
  logic              own_upd, bc_upd, ok_upd, pv;
  logic [7:0]        hi_upd;
  logic [MAC_W-1:0]  src_upd;
  logic [CNT_W-1:0]  pl;
  logic [EXT_W-1:0]  pl_ext;
  logic              long_enough;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      match_type_q <= TYPE_RESET;
      capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_OWN_MAC: own_mac_q <= cfg_data_i[MAC_W-1:0];
        REG_MATCH_TYPE: match_type_q <= cfg_data_i[TYPE_W-1:0];
        REG_PAYLOAD_CAP: capacity_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign idx = count_q;
  assign keep = idx < CNT_W'(MAX_FRAME_BYTES);

  // Expected destination byte, first wire byte in the top bits.
  always_comb begin
    unique case (idx[2:0])
      3'd0: want = own_mac_q[47:40];
      3'd1: want = own_mac_q[39:32];
      3'd2: want = own_mac_q[31:24];
      3'd3: want = own_mac_q[23:16];
      3'd4: want = own_mac_q[15:8];
      3'd5: want = own_mac_q[7:0];
      default: want = own_mac_q[7:0];
    endcase
  end

  always_comb begin
    own_upd = dst_own_q;
    bc_upd = dst_bc_q;
    hi_upd = type_hi_q;
    ok_upd = type_ok_q;
    src_upd = src_q;
    pv = 1'b0;
    cnt_upd = count_q;
    if (keep) begin
      cnt_upd = idx + CNT_W'(1);
      if (idx < CNT_W'(DST_END)) begin
        if (beat_i.frame_byte != want) own_upd = 1'b0;
        if (beat_i.frame_byte != BCAST_BYTE) bc_upd = 1'b0;
      end else if (idx < CNT_W'(SRC_END)) begin
        src_upd = {src_q[MAC_W-9:0], beat_i.frame_byte};
      end else if (idx == CNT_W'(TYPE_HI_IDX)) begin
        hi_upd = beat_i.frame_byte;
      end else if (idx == CNT_W'(TYPE_LO_IDX)) begin
        ok_upd = ({type_hi_q, beat_i.frame_byte} == match_type_q);
      end else begin
        pv = 1'b1;
      end
    end
  end

  assign long_enough = cnt_upd >= CNT_W'(HDR_LEN);
  assign pl = long_enough ? cnt_upd - CNT_W'(HDR_LEN) : '0;
  assign pl_ext = EXT_W'(pl);

  always_comb begin
    result_o.payload_valid = pv;
    result_o.payload_byte = pv ? beat_i.frame_byte : 8'd0;
    result_o.frame_done = beat_i.frame_last;
    result_o.accepted = 1'b0;
    result_o.source_address = '0;
    result_o.pay_len = '0;
    if (beat_i.frame_last) begin
      result_o.accepted = long_enough && ok_upd && (own_upd || bc_upd)
                          && (pl_ext <= EXT_W'(capacity_q));
      result_o.source_address = src_upd;
      result_o.pay_len = (pl_ext > EXT_W'({LEN_W{1'b1}})) ? {LEN_W{1'b1}}
                                                           : pl_ext[LEN_W-1:0];
    end
  end

  // Clear per-frame state after the last beat.
  always_comb begin
    count_d = count_q;
    dst_own_d = dst_own_q;
    dst_bc_d = dst_bc_q;
    type_hi_d = type_hi_q;
    type_ok_d = type_ok_q;
    src_d = src_q;
    if (advance_i) begin
      if (beat_i.frame_last) begin
        count_d = '0;
        dst_own_d = 1'b1;
        dst_bc_d = 1'b1;
        type_hi_d = '0;
        type_ok_d = 1'b0;
        src_d = '0;
      end else begin
        count_d = cnt_upd;
        dst_own_d = own_upd;
        dst_bc_d = bc_upd;
        type_hi_d = hi_upd;
        type_ok_d = ok_upd;
        src_d = src_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      dst_own_q <= 1'b1;
      dst_bc_q <= 1'b1;
      type_hi_q <= '0;
      type_ok_q <= 1'b0;
      src_q <= '0;
    end else begin
      count_q <= count_d;
      dst_own_q <= dst_own_d;
      dst_bc_q <= dst_bc_d;
      type_hi_q <= type_hi_d;
      type_ok_q <= type_ok_d;
      src_q <= src_d;
    end
  end

endmodule

>>> rtl/efm_out_stage.sv
// Result register stage: holds one result beat until downstream takes it.
module efm_out_stage
  import efm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_valid_i,
  output logic        load_ready_o,
  input  efm_result_t result_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output efm_result_t result_o
);

  logic        valid_q, valid_d;
  efm_result_t result_q;

  assign load_ready_o = !valid_q || out_ready_i;
  assign valid_d = load_ready_o ? load_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ready_o && load_valid_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o = result_q;

endmodule

>>> rtl/ethertype_mac_frame_filter.sv
// Path: a byte beat accepted into the input register is loaded into the result register,
// where its result beat waits until downstream takes it.
// Throughput: one byte beat per cycle; input ready follows result ready combinationally,
// so a new beat is blocked only while a result beat waits on downstream.
// Reset: asynchronous, active low; clears stage valids, frame state and
// loads register defaults (own MAC 0, ethertype 0x88B6, capacity 1500).
module ethertype_mac_frame_filter
  import efm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] frame_byte
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] payload_byte, [8] accepted, [56:9] source_address,
  // [67:57] pay_len, [71:68] zero
  output logic [71:0]           m_axis_tdata,
  output logic [0:0]            m_axis_tuser,  // [0] payload_valid
  output logic                  m_axis_tlast,  // frame_done
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  efm_beat_t   in_beat, beat;
  efm_result_t result, out_result;
  logic        beat_valid, load_ready, advance;

  assign in_beat.frame_byte = s_axis_tdata;
  assign in_beat.frame_last = s_axis_tlast;
  assign advance = beat_valid && load_ready;

  efm_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_beat_i    (in_beat),
    .beat_valid_o (beat_valid),
    .beat_o       (beat),
    .advance_i    (advance)
  );

  efm_frame_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .advance_i  (advance),
    .beat_i     (beat),
    .result_o   (result)
  );

  efm_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (beat_valid),
    .load_ready_o (load_ready),
    .result_i     (result),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .result_o     (out_result)
  );

  assign m_axis_tdata = {4'd0, out_result.pay_len, out_result.source_address,
                         out_result.accepted, out_result.payload_byte};
  assign m_axis_tuser = out_result.payload_valid;
  assign m_axis_tlast = out_result.frame_done;

endmodule
